### sv/asgr_pkg.sv
// Shared types, character codes and color-cube helpers for the SGR decoder.
package asgr_pkg;

  localparam logic [7:0] CH_ESC = 8'h1B;

  localparam int COLOR_BITS = 11;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = 2;

  typedef logic signed [COLOR_BITS-1:0] color_t;

  localparam color_t COLOR_DEFAULT = '1;

  localparam logic [2:0] STYLE_BOLD  = 3'b001;
  localparam logic [2:0] STYLE_ULINE = 3'b010;
  localparam logic [2:0] STYLE_REV   = 3'b100;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_TEXT,
    OP_TEXT2,
    OP_WALK
  } op_t;

  // One command from the front to the back; clear returns attributes to default after it.
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       clear;
  } cmd_t;

  function automatic logic [2:0] cube_step(input logic [7:0] v);
    if (v < 8'd48) begin
      return 3'd0;
    end else if (v < 8'd115) begin
      return 3'd1;
    end else if (v < 8'd155) begin
      return 3'd2;
    end else if (v < 8'd195) begin
      return 3'd3;
    end else if (v < 8'd235) begin
      return 3'd4;
    end
    return 3'd5;
  endfunction

  function automatic logic [7:0] cube_level(input logic [2:0] i);
    logic [7:0] lv;
    case (i)
      3'd0:    lv = 8'd0;
      3'd1:    lv = 8'd95;
      3'd2:    lv = 8'd135;
      3'd3:    lv = 8'd175;
      3'd4:    lv = 8'd215;
      default: lv = 8'd255;
    endcase
    return lv;
  endfunction

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

### sv/asgr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module asgr_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### sv/asgr_cmdq.sv
// Short command queue between the byte scanner and the attribute engine.
module asgr_cmdq import asgr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  cmd_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wptr_r, wptr_nxt;
  logic [Q_AW-1:0] rptr_r, rptr_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wptr_r] <= din;
    end
  end

endmodule

### sv/asgr_front.sv
// Byte scanner: tracks escape state, gathers CSI parameters and issues commands.
module asgr_front import asgr_pkg::*; #(
  parameter int MAX_PARAMS = 16,
  parameter int PARAM_BITS = 10,
  localparam int CW = $clog2(MAX_PARAMS + 1),
  localparam int AW = $clog2(MAX_PARAMS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [7:0]            in_byte,
  input  logic                  in_line_last,
  input  logic                  q_full,
  output logic                  q_push,
  output cmd_t                  q_data,
  input  logic                  walk_done,
  output logic [CW-1:0]         walk_count,
  output logic                  walk_dropped,
  output logic                  ram_we,
  output logic [AW-1:0]         ram_waddr,
  output logic [PARAM_BITS-1:0] ram_wdata
);

  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_FINAL_M  = 8'h6D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [PARAM_BITS-1:0] PARAM_SAT = '1;

  typedef enum logic [1:0] {
    M_TEXT = 2'd0,
    M_ESC  = 2'd1,
    M_CSI  = 2'd2
  } mode_t;

  mode_t                 mode_r, mode_nxt;
  logic [PARAM_BITS-1:0] accum_r, accum_nxt;
  logic                  seen_r, seen_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  busy_r, busy_nxt;
  logic [CW-1:0]         walk_n_r, walk_n_nxt;
  logic                  walk_drop_r, walk_drop_nxt;

  logic                  accept;
  logic                  is_digit;
  logic                  room;
  logic [PARAM_BITS+3:0] acc_wide;

  // The parameter store belongs to the walk in flight; hold CSI bytes until it ends.
  assign in_full      = q_full || (busy_r && (mode_r == M_CSI));
  assign accept       = in_push && !in_full;
  assign is_digit     = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign room         = (count_r < CW'(MAX_PARAMS));
  assign acc_wide     = ({4'b0000, accum_r} << 3) + ({4'b0000, accum_r} << 1)
                      + {{PARAM_BITS{1'b0}}, in_byte[3:0]};
  assign walk_count   = walk_n_r;
  assign walk_dropped = walk_drop_r;

  always_comb begin
    mode_nxt      = mode_r;
    accum_nxt     = accum_r;
    seen_nxt      = seen_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    busy_nxt      = busy_r;
    walk_n_nxt    = walk_n_r;
    walk_drop_nxt = walk_drop_r;
    q_push        = 1'b0;
    q_data.op     = OP_NONE;
    q_data.data   = in_byte;
    q_data.clear  = in_line_last;
    ram_we        = 1'b0;
    ram_waddr     = count_r[AW-1:0];
    ram_wdata     = seen_r ? accum_r : '0;

    if (walk_done) begin
      busy_nxt = 1'b0;
    end

    if (accept) begin
      unique case (mode_r)
        M_CSI: begin
          if (is_digit) begin
            accum_nxt = (acc_wide[PARAM_BITS+3:PARAM_BITS] != 4'd0) ? PARAM_SAT
                                                                     : acc_wide[PARAM_BITS-1:0];
            seen_nxt  = 1'b1;
          end else begin
            if (room) begin
              ram_we    = 1'b1;
              count_nxt = count_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
            accum_nxt = '0;
            seen_nxt  = 1'b0;
            if (in_byte != CH_SEMI) begin
              mode_nxt = M_TEXT;
              if (in_byte == CH_FINAL_M) begin
                q_push        = 1'b1;
                q_data.op     = OP_WALK;
                walk_n_nxt    = room ? count_r + 1'b1 : count_r;
                walk_drop_nxt = ovf_r || !room;
                busy_nxt      = 1'b1;
              end
            end
          end
        end
        M_ESC: begin
          if (in_byte == CH_LBRACKET) begin
            mode_nxt  = M_CSI;
            accum_nxt = '0;
            seen_nxt  = 1'b0;
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end else begin
            q_push = 1'b1;
            if ((in_byte == CH_ESC) && !in_line_last) begin
              q_data.op = OP_TEXT;
            end else begin
              q_data.op = OP_TEXT2;
              mode_nxt  = M_TEXT;
            end
          end
        end
        default: begin
          if ((in_byte == CH_ESC) && !in_line_last) begin
            mode_nxt = M_ESC;
          end else begin
            q_push    = 1'b1;
            q_data.op = OP_TEXT;
          end
        end
      endcase

      // End of line: always send a command so the back end drops the attributes.
      if (in_line_last) begin
        q_push    = 1'b1;
        mode_nxt  = M_TEXT;
        accum_nxt = '0;
        seen_nxt  = 1'b0;
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_TEXT;
      accum_r     <= '0;
      seen_r      <= 1'b0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      busy_r      <= 1'b0;
      walk_n_r    <= '0;
      walk_drop_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      accum_r     <= accum_nxt;
      seen_r      <= seen_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      busy_r      <= busy_nxt;
      walk_n_r    <= walk_n_nxt;
      walk_drop_r <= walk_drop_nxt;
    end
  end

endmodule

### sv/asgr_back.sv
// Attribute engine: walks stored SGR parameters, maps RGB colors, drives the result register.
module asgr_back import asgr_pkg::*; #(
  parameter int MAX_PARAMS = 16,
  parameter int PARAM_BITS = 10,
  localparam int CW = $clog2(MAX_PARAMS + 1),
  localparam int AW = $clog2(MAX_PARAMS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  cmd_t                  q_data,
  output logic                  q_pop,
  input  logic [CW-1:0]         walk_count,
  input  logic                  walk_dropped,
  output logic                  walk_done,
  output logic [AW-1:0]         ram_raddr,
  input  logic [PARAM_BITS-1:0] ram_rdata,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic                  out_kind,
  output logic [7:0]            out_text_byte,
  output color_t                out_fg_color,
  output color_t                out_bg_color,
  output logic                  out_bold_on,
  output logic                  out_underline_on,
  output logic                  out_reverse_on,
  output logic                  out_params_dropped,
  output logic                  out_run_last
);

  localparam logic [PARAM_BITS-1:0] SGR_RESET     = PARAM_BITS'(0);
  localparam logic [PARAM_BITS-1:0] SGR_BOLD      = PARAM_BITS'(1);
  localparam logic [PARAM_BITS-1:0] SGR_ULINE     = PARAM_BITS'(4);
  localparam logic [PARAM_BITS-1:0] SGR_REV       = PARAM_BITS'(7);
  localparam logic [PARAM_BITS-1:0] SGR_BOLD_OFF  = PARAM_BITS'(22);
  localparam logic [PARAM_BITS-1:0] SGR_ULINE_OFF = PARAM_BITS'(24);
  localparam logic [PARAM_BITS-1:0] SGR_REV_OFF   = PARAM_BITS'(27);
  localparam logic [PARAM_BITS-1:0] SGR_FG_LO     = PARAM_BITS'(30);
  localparam logic [PARAM_BITS-1:0] SGR_FG_HI     = PARAM_BITS'(37);
  localparam logic [PARAM_BITS-1:0] SGR_FG_EXT    = PARAM_BITS'(38);
  localparam logic [PARAM_BITS-1:0] SGR_FG_DEF    = PARAM_BITS'(39);
  localparam logic [PARAM_BITS-1:0] SGR_BG_LO     = PARAM_BITS'(40);
  localparam logic [PARAM_BITS-1:0] SGR_BG_HI     = PARAM_BITS'(47);
  localparam logic [PARAM_BITS-1:0] SGR_BG_EXT    = PARAM_BITS'(48);
  localparam logic [PARAM_BITS-1:0] SGR_BG_DEF    = PARAM_BITS'(49);
  localparam logic [PARAM_BITS-1:0] SGR_FGB_LO    = PARAM_BITS'(90);
  localparam logic [PARAM_BITS-1:0] SGR_FGB_HI    = PARAM_BITS'(97);
  localparam logic [PARAM_BITS-1:0] SGR_BGB_LO    = PARAM_BITS'(100);
  localparam logic [PARAM_BITS-1:0] SGR_BGB_HI    = PARAM_BITS'(107);
  localparam logic [PARAM_BITS-1:0] EXT_INDEX     = PARAM_BITS'(5);
  localparam logic [PARAM_BITS-1:0] EXT_RGB       = PARAM_BITS'(2);
  localparam logic [PARAM_BITS-1:0] RGB_MAX       = PARAM_BITS'(255);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TEXT2,
    S_FETCH,
    S_CODE,
    S_SEL,
    S_IDX,
    S_R,
    S_G,
    S_B,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_EMIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] p_r, p_nxt;
  logic          tgt_bg_r, tgt_bg_nxt;
  color_t        fg_r, fg_nxt;
  color_t        bg_r, bg_nxt;
  logic [2:0]    style_r, style_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [7:0]    r_r, r_nxt, g_r, g_nxt, b_r, b_nxt;
  logic [2:0]    ir_r, ir_nxt, ig_r, ig_nxt, ib_r, ib_nxt;
  logic [7:0]    adr_r, adr_nxt, adg_r, adg_nxt, adb_r, adb_nxt;
  logic [7:0]    avg_r, avg_nxt;
  logic [4:0]    slot_r, slot_nxt;
  logic [7:0]    lvl_r, lvl_nxt;
  logic [17:0]   cdist_r, cdist_nxt;
  logic [17:0]   gdist_r, gdist_nxt;

  logic          ovalid_r, ovalid_nxt;
  logic          okind_r, okind_nxt;
  logic [7:0]    obyte_r, obyte_nxt;
  color_t        ofg_r, ofg_nxt;
  color_t        obg_r, obg_nxt;
  logic [2:0]    ostyle_r, ostyle_nxt;
  logic          odrop_r, odrop_nxt;
  logic          olast_r, olast_nxt;

  logic                  slot_free;
  logic [CW+2:0]         pw, nw, raddr_w;
  logic [PARAM_BITS-1:0] v;
  logic [6:0]            vlo;
  logic [7:0]            rd_clamp;
  logic [COLOR_BITS-1:0] rd_color;
  logic [9:0]            sum_rgb;
  logic [19:0]           avg_prod;
  logic [2:0]            ir_c, ig_c, ib_c;
  logic [7:0]            gray_off;
  logic [15:0]           slot_prod;
  logic [4:0]            slot_c;
  logic [7:0]            lvl_c;
  logic [17:0]           cdist_c, gdist_c;
  logic [7:0]            agr_c, agg_c, agb_c;
  logic [7:0]            map_idx;

  assign out_empty          = !ovalid_r;
  assign out_kind           = okind_r;
  assign out_text_byte      = obyte_r;
  assign out_fg_color       = ofg_r;
  assign out_bg_color       = obg_r;
  assign out_bold_on        = ostyle_r[0];
  assign out_underline_on   = ostyle_r[1];
  assign out_reverse_on     = ostyle_r[2];
  assign out_params_dropped = odrop_r;
  assign out_run_last       = olast_r;

  assign slot_free = !ovalid_r || out_pop;
  assign pw        = {3'b000, p_r};
  assign nw        = {3'b000, walk_count};
  assign v         = ram_rdata;
  assign vlo       = ram_rdata[6:0];
  assign rd_clamp  = (ram_rdata > RGB_MAX) ? 8'hFF : ram_rdata[7:0];
  assign rd_color  = COLOR_BITS'(ram_rdata);

  // RGB mapping datapath, one register stage per step.
  assign ir_c      = cube_step(r_r);
  assign ig_c      = cube_step(g_r);
  assign ib_c      = cube_step(b_r);
  assign sum_rgb   = {2'b00, r_r} + {2'b00, g_r} + {2'b00, b_r};
  assign avg_prod  = 20'(sum_rgb) * 20'd683;
  assign gray_off  = avg_r - 8'd3;
  assign slot_prod = 16'(gray_off) * 16'd205;
  assign slot_c    = (avg_r > 8'd238) ? 5'd23 : ((avg_r < 8'd3) ? 5'd0 : slot_prod[15:11]);
  assign lvl_c     = 8'(slot_c) * 8'd10 + 8'd8;
  assign cdist_c   = 18'(adr_r) * 18'(adr_r) + 18'(adg_r) * 18'(adg_r)
                   + 18'(adb_r) * 18'(adb_r);
  assign agr_c     = abs_diff(r_r, lvl_r);
  assign agg_c     = abs_diff(g_r, lvl_r);
  assign agb_c     = abs_diff(b_r, lvl_r);
  assign gdist_c   = 18'(agr_c) * 18'(agr_c) + 18'(agg_c) * 18'(agg_c)
                   + 18'(agb_c) * 18'(agb_c);
  assign map_idx   = (gdist_r < cdist_r) ? (8'd232 + 8'(slot_r))
                   : (8'd16 + 8'(ir_r) * 8'd36 + 8'(ig_r) * 8'd6 + 8'(ib_r));

  always_comb begin
    unique case (state_r)
      S_CODE:  raddr_w = pw + (CW+3)'(1);
      S_SEL:   raddr_w = pw + (CW+3)'(2);
      S_R:     raddr_w = pw + (CW+3)'(3);
      S_G:     raddr_w = pw + (CW+3)'(4);
      default: raddr_w = pw;
    endcase
    ram_raddr = raddr_w[AW-1:0];
  end

  always_comb begin
    state_nxt  = state_r;
    p_nxt      = p_r;
    tgt_bg_nxt = tgt_bg_r;
    fg_nxt     = fg_r;
    bg_nxt     = bg_r;
    style_nxt  = style_r;
    cmd_nxt    = cmd_r;
    r_nxt      = r_r;
    g_nxt      = g_r;
    b_nxt      = b_r;
    ir_nxt     = ir_r;
    ig_nxt     = ig_r;
    ib_nxt     = ib_r;
    adr_nxt    = adr_r;
    adg_nxt    = adg_r;
    adb_nxt    = adb_r;
    avg_nxt    = avg_r;
    slot_nxt   = slot_r;
    lvl_nxt    = lvl_r;
    cdist_nxt  = cdist_r;
    gdist_nxt  = gdist_r;
    ovalid_nxt = ovalid_r && !out_pop;
    okind_nxt  = okind_r;
    obyte_nxt  = obyte_r;
    ofg_nxt    = ofg_r;
    obg_nxt    = obg_r;
    ostyle_nxt = ostyle_r;
    odrop_nxt  = odrop_r;
    olast_nxt  = olast_r;
    q_pop      = 1'b0;
    walk_done  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          unique case (q_data.op)
            OP_TEXT: begin
              if (slot_free) begin
                q_pop      = 1'b1;
                ovalid_nxt = 1'b1;
                okind_nxt  = 1'b0;
                obyte_nxt  = q_data.data;
                ofg_nxt    = fg_r;
                obg_nxt    = bg_r;
                ostyle_nxt = style_r;
                odrop_nxt  = 1'b0;
                olast_nxt  = 1'b1;
                if (q_data.clear) begin
                  fg_nxt    = COLOR_DEFAULT;
                  bg_nxt    = COLOR_DEFAULT;
                  style_nxt = '0;
                end
              end
            end
            OP_TEXT2: begin
              // Lone escape goes out first, the byte after it follows.
              if (slot_free) begin
                q_pop      = 1'b1;
                cmd_nxt    = q_data;
                ovalid_nxt = 1'b1;
                okind_nxt  = 1'b0;
                obyte_nxt  = CH_ESC;
                ofg_nxt    = fg_r;
                obg_nxt    = bg_r;
                ostyle_nxt = style_r;
                odrop_nxt  = 1'b0;
                olast_nxt  = 1'b0;
                state_nxt  = S_TEXT2;
              end
            end
            OP_WALK: begin
              q_pop     = 1'b1;
              cmd_nxt   = q_data;
              p_nxt     = '0;
              state_nxt = S_FETCH;
            end
            OP_NONE: begin
              q_pop = 1'b1;
              if (q_data.clear) begin
                fg_nxt    = COLOR_DEFAULT;
                bg_nxt    = COLOR_DEFAULT;
                style_nxt = '0;
              end
            end
          endcase
        end
      end
      S_TEXT2: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          okind_nxt  = 1'b0;
          obyte_nxt  = cmd_r.data;
          ofg_nxt    = fg_r;
          obg_nxt    = bg_r;
          ostyle_nxt = style_r;
          odrop_nxt  = 1'b0;
          olast_nxt  = 1'b1;
          if (cmd_r.clear) begin
            fg_nxt    = COLOR_DEFAULT;
            bg_nxt    = COLOR_DEFAULT;
            style_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      S_FETCH: begin
        state_nxt = (pw >= nw) ? S_EMIT : S_CODE;
      end
      S_CODE: begin
        p_nxt     = p_r + 1'b1;
        state_nxt = S_FETCH;
        if (v == SGR_RESET) begin
          fg_nxt    = COLOR_DEFAULT;
          bg_nxt    = COLOR_DEFAULT;
          style_nxt = '0;
        end else if (v == SGR_BOLD) begin
          style_nxt = style_r | STYLE_BOLD;
        end else if (v == SGR_ULINE) begin
          style_nxt = style_r | STYLE_ULINE;
        end else if (v == SGR_REV) begin
          style_nxt = style_r | STYLE_REV;
        end else if (v == SGR_BOLD_OFF) begin
          style_nxt = style_r & ~STYLE_BOLD;
        end else if (v == SGR_ULINE_OFF) begin
          style_nxt = style_r & ~STYLE_ULINE;
        end else if (v == SGR_REV_OFF) begin
          style_nxt = style_r & ~STYLE_REV;
        end else if ((v >= SGR_FG_LO) && (v <= SGR_FG_HI)) begin
          fg_nxt = {4'b0000, vlo - 7'd30};
        end else if ((v >= SGR_BG_LO) && (v <= SGR_BG_HI)) begin
          bg_nxt = {4'b0000, vlo - 7'd40};
        end else if ((v >= SGR_FGB_LO) && (v <= SGR_FGB_HI)) begin
          fg_nxt = {4'b0000, vlo - 7'd82};
        end else if ((v >= SGR_BGB_LO) && (v <= SGR_BGB_HI)) begin
          bg_nxt = {4'b0000, vlo - 7'd92};
        end else if (v == SGR_FG_DEF) begin
          fg_nxt = COLOR_DEFAULT;
        end else if (v == SGR_BG_DEF) begin
          bg_nxt = COLOR_DEFAULT;
        end else if ((v == SGR_FG_EXT) || (v == SGR_BG_EXT)) begin
          // Selector needs a following parameter; otherwise skip just this one.
          if (pw + (CW+3)'(1) < nw) begin
            p_nxt      = p_r;
            tgt_bg_nxt = (v == SGR_BG_EXT);
            state_nxt  = S_SEL;
          end
        end
      end
      S_SEL: begin
        if ((v == EXT_INDEX) && (pw + (CW+3)'(2) < nw)) begin
          state_nxt = S_IDX;
        end else if ((v == EXT_RGB) && (pw + (CW+3)'(4) < nw)) begin
          state_nxt = S_R;
        end else begin
          p_nxt     = p_r + 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_IDX: begin
        if (tgt_bg_r) begin
          bg_nxt = rd_color;
        end else begin
          fg_nxt = rd_color;
        end
        p_nxt     = p_r + CW'(3);
        state_nxt = S_FETCH;
      end
      S_R: begin
        r_nxt     = rd_clamp;
        state_nxt = S_G;
      end
      S_G: begin
        g_nxt     = rd_clamp;
        state_nxt = S_B;
      end
      S_B: begin
        b_nxt     = rd_clamp;
        state_nxt = S_M1;
      end
      S_M1: begin
        ir_nxt    = ir_c;
        ig_nxt    = ig_c;
        ib_nxt    = ib_c;
        adr_nxt   = abs_diff(r_r, cube_level(ir_c));
        adg_nxt   = abs_diff(g_r, cube_level(ig_c));
        adb_nxt   = abs_diff(b_r, cube_level(ib_c));
        avg_nxt   = avg_prod[18:11];
        state_nxt = S_M2;
      end
      S_M2: begin
        slot_nxt  = slot_c;
        lvl_nxt   = lvl_c;
        cdist_nxt = cdist_c;
        state_nxt = S_M3;
      end
      S_M3: begin
        gdist_nxt = gdist_c;
        state_nxt = S_M4;
      end
      S_M4: begin
        if (tgt_bg_r) begin
          bg_nxt = {3'b000, map_idx};
        end else begin
          fg_nxt = {3'b000, map_idx};
        end
        p_nxt     = p_r + CW'(5);
        state_nxt = S_FETCH;
      end
      S_EMIT: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          okind_nxt  = 1'b1;
          obyte_nxt  = 8'h00;
          ofg_nxt    = fg_r;
          obg_nxt    = bg_r;
          ostyle_nxt = style_r;
          odrop_nxt  = walk_dropped;
          olast_nxt  = 1'b1;
          walk_done  = 1'b1;
          if (cmd_r.clear) begin
            fg_nxt    = COLOR_DEFAULT;
            bg_nxt    = COLOR_DEFAULT;
            style_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fg_r     <= COLOR_DEFAULT;
      bg_r     <= COLOR_DEFAULT;
      style_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fg_r     <= fg_nxt;
      bg_r     <= bg_nxt;
      style_r  <= style_nxt;
      ovalid_r <= ovalid_nxt;
    end
    p_r      <= p_nxt;
    tgt_bg_r <= tgt_bg_nxt;
    cmd_r    <= cmd_nxt;
    r_r      <= r_nxt;
    g_r      <= g_nxt;
    b_r      <= b_nxt;
    ir_r     <= ir_nxt;
    ig_r     <= ig_nxt;
    ib_r     <= ib_nxt;
    adr_r    <= adr_nxt;
    adg_r    <= adg_nxt;
    adb_r    <= adb_nxt;
    avg_r    <= avg_nxt;
    slot_r   <= slot_nxt;
    lvl_r    <= lvl_nxt;
    cdist_r  <= cdist_nxt;
    gdist_r  <= gdist_nxt;
    okind_r  <= okind_nxt;
    obyte_r  <= obyte_nxt;
    ofg_r    <= ofg_nxt;
    obg_r    <= obg_nxt;
    ostyle_r <= ostyle_nxt;
    odrop_r  <= odrop_nxt;
    olast_r  <= olast_nxt;
  end

endmodule

### sv/ansi_sgr_attribute_decoder.sv
// A text byte passes through the command queue and the result register; the byte after a lone
// ESC follows it once the result slot is free. Throughput: one text byte per cycle while results
// are popped and no walk is running. An SGR 'm' walk runs fetch and code per parameter, adds
// select and index for 38/48;5;n, select, R, G, B and M1 to M4 for 38/48;2;r;g;b, then emits.
// CSI bytes of the next sequence wait while a walk is in progress; other bytes keep queueing.
// Reset (rst_n low, synchronous) empties both queues and sets default attributes.
module ansi_sgr_attribute_decoder import asgr_pkg::*; #(
  parameter int MAX_PARAMS = 16,
  parameter int PARAM_BITS = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_byte,
  input  logic       in_line_last,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_kind,
  output logic [7:0] out_text_byte,
  output color_t     out_fg_color,
  output color_t     out_bg_color,
  output logic       out_bold_on,
  output logic       out_underline_on,
  output logic       out_reverse_on,
  output logic       out_params_dropped,
  output logic       out_run_last
);

  localparam int CW = $clog2(MAX_PARAMS + 1);
  localparam int AW = $clog2(MAX_PARAMS);

  logic                  q_push, q_full, q_pop, q_empty;
  cmd_t                  q_wdata, q_rdata;
  logic                  walk_done, walk_dropped;
  logic [CW-1:0]         walk_count;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [PARAM_BITS-1:0] ram_wdata, ram_rdata;

  asgr_front #(
    .MAX_PARAMS(MAX_PARAMS),
    .PARAM_BITS(PARAM_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_byte      (in_byte),
    .in_line_last (in_line_last),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata),
    .walk_done    (walk_done),
    .walk_count   (walk_count),
    .walk_dropped (walk_dropped),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata)
  );

  asgr_ram #(
    .WIDTH(PARAM_BITS),
    .DEPTH(MAX_PARAMS)
  ) u_param_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  asgr_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_rdata),
    .empty (q_empty)
  );

  asgr_back #(
    .MAX_PARAMS(MAX_PARAMS),
    .PARAM_BITS(PARAM_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_data             (q_rdata),
    .q_pop              (q_pop),
    .walk_count         (walk_count),
    .walk_dropped       (walk_dropped),
    .walk_done          (walk_done),
    .ram_raddr          (ram_raddr),
    .ram_rdata          (ram_rdata),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_kind           (out_kind),
    .out_text_byte      (out_text_byte),
    .out_fg_color       (out_fg_color),
    .out_bg_color       (out_bg_color),
    .out_bold_on        (out_bold_on),
    .out_underline_on   (out_underline_on),
    .out_reverse_on     (out_reverse_on),
    .out_params_dropped (out_params_dropped),
    .out_run_last       (out_run_last)
  );

endmodule

### sv/asgr_checker.sv
// Port-level checks on the decoder, attached to the top level by bind.
module asgr_checker import asgr_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic       out_kind,
  input logic [7:0] out_text_byte,
  input color_t     out_fg_color,
  input color_t     out_bg_color,
  input logic       out_bold_on,
  input logic       out_underline_on,
  input logic       out_reverse_on,
  input logic       out_params_dropped,
  input logic       out_run_last
);

  // A waiting result holds until popped.
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_kind)
      && $stable(out_text_byte) && $stable(out_fg_color) && $stable(out_bg_color)
      && $stable(out_bold_on) && $stable(out_underline_on) && $stable(out_reverse_on)
      && $stable(out_params_dropped) && $stable(out_run_last)))
    else $error("result changed while waiting");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // An attribute result always closes its transaction and carries no text.
  a_attr_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind) |-> (out_run_last && (out_text_byte == 8'h00)))
    else $error("malformed attribute result");

  a_text_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_kind) |-> !out_params_dropped)
    else $error("drop flag on text result");

endmodule

bind ansi_sgr_attribute_decoder asgr_checker u_asgr_checker (.*);
